/* sv/pets_pkg.sv */
`timescale 1ns / 1ps

package pets_pkg;

  // field widths fixed by the item formats
  localparam int TID_W      = 6;
  localparam int PRIO_IN_W  = 3;
  localparam int CNT_W      = 7;
  localparam int QNT_W      = 8;

  // thread id space and link memory depth
  localparam int ID_DEPTH   = 1 << TID_W;

  // quantum table: one register per priority code
  localparam int NUM_QREG   = 8;
  localparam int QREG_IDX_W = 3;
  localparam int CFG_IDX_W  = 4;
  localparam logic [QNT_W-1:0] QUANTUM_RST = 8'd10;

  // default number of priority levels
  localparam int NUM_PRIO_DEF = 8;

  // per-queue capacity: the thread limit, bounded by the counter range
  localparam int MAX_THREADS = 64;
  localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;
  localparam logic [CNT_W-1:0] QUEUE_CAP =
    (MAX_THREADS < 127) ? CNT_W'(MAX_THREADS) : CNT_MAX;

  // item kinds
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [TID_W-1:0]     thread_id;
    logic [PRIO_IN_W-1:0] thread_prio;
    logic                 current_exited;
    logic                 is_running;
  } in_item_t;

  typedef struct packed {
    logic [TID_W-1:0] running_thread;
    logic             running_ok;
    logic             switched;
    logic             epoch_swapped;
  } out_item_t;

endpackage

/* sv/priority_epoch_thread_scheduler.sv */
`timescale 1ns / 1ps

// Thread scheduler with active and expired banks of per-priority FIFOs.
// An item is taken when start is high and busy is low; its result comes
// out on out_data with out_valid high for exactly one cycle and must be
// taken then, as there is no way to hold it off. The next item may be
// given in that same cycle. An insert of a running thread and a plain tick
// are the quickest; a tick that leaves nothing running, an insert into a
// queue, a tick that selects a successor and a tick whose thread expires
// and is replaced take longer, in that order. A sequencer walks the queue
// head/tail memory and the link memory, each with one synchronous read
// port, read, modified and written back one step at a time. The quantum
// registers take writes on the cfg port at any time (cfg_ready is always
// high); indexes beyond the table are ignored. No clearing pass follows
// reset.
module priority_epoch_thread_scheduler #(
  parameter int NUM_PRIO = pets_pkg::NUM_PRIO_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  pets_pkg::in_item_t               in_data,
  output logic                             out_valid,
  output pets_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pets_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pets_pkg::QNT_W-1:0]       cfg_data
);

  localparam int NQ = 2 * NUM_PRIO;
  localparam int QW = $clog2(NQ);
  localparam int PW = (NUM_PRIO > 1) ? $clog2(NUM_PRIO) : 1;
  localparam int TW = pets_pkg::TID_W;
  localparam int CW = pets_pkg::CNT_W;

  typedef struct packed {
    logic [TW-1:0] head;
    logic [TW-1:0] tail;
  } ht_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_PUSH_RD,
    S_PUSH_WR,
    S_SEL,
    S_POP_RD,
    S_POP_WR,
    S_DONE
  } state_t;

  // saturating counter steps
  function automatic logic [CW-1:0] inc_sat(input logic [CW-1:0] v);
    return (v < pets_pkg::CNT_MAX) ? v + CW'(1) : v;
  endfunction

  function automatic logic [CW-1:0] dec_sat(input logic [CW-1:0] v);
    return (v != '0) ? v - CW'(1) : '0;
  endfunction

  // queue number of a bank and priority
  function automatic logic [QW-1:0] qidx(input logic bank, input logic [PW-1:0] p);
    return (bank ? QW'(NUM_PRIO) : QW'(0)) + QW'(p);
  endfunction

  state_t                         state_r;
  pets_pkg::in_item_t             item_r;
  logic [pets_pkg::QNT_W-1:0]     quantum_r [pets_pkg::NUM_QREG];
  logic [CW-1:0]                  qsize_r [NQ];
  logic                           bank_r;
  logic [CW-1:0]                  thread_total_r;
  logic [CW-1:0]                  active_total_r;
  logic [CW-1:0]                  expired_total_r;
  logic [TW-1:0]                  run_id_r;
  logic [PW-1:0]                  run_prio_r;
  logic [pets_pkg::QNT_W-1:0]     run_quantum_r;
  logic                           run_valid_r;
  logic                           switched_r;
  logic                           swapped_r;
  logic [QW-1:0]                  push_q_r;
  logic [TW-1:0]                  push_id_r;
  logic                           then_sel_r;
  logic [QW-1:0]                  pop_q_r;
  logic                           out_valid_r;
  pets_pkg::out_item_t            out_data_r;

  // queue head/tail memory and link memory
  ht_entry_t                      ht_mem [NQ];
  ht_entry_t                      ht_rd_r;
  logic [TW-1:0]                  link_mem [pets_pkg::ID_DEPTH];
  logic [TW-1:0]                  link_rd_r;

  logic [PW-1:0]                  item_prio;
  logic [CW-1:0]                  push_size;
  logic                           push_ok;
  logic                           bank_eff;
  logic                           sel_found;
  logic [PW-1:0]                  sel_p;
  logic [QW-1:0]                  sel_q;
  logic [QW-1:0]                  ht_raddr;
  logic                           ht_we;
  logic [QW-1:0]                  ht_waddr;
  ht_entry_t                      ht_wdata;
  logic                           link_we;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // priority of the item, out-of-range codes fold to the lowest level
  always_comb begin
    if (int'(item_r.thread_prio) >= NUM_PRIO) begin
      item_prio = PW'(NUM_PRIO - 1);
    end else begin
      item_prio = item_r.thread_prio[PW-1:0];
    end
  end

  // capacity check for the queue being pushed
  assign push_size = qsize_r[push_q_r];
  assign push_ok   = (push_size < pets_pkg::QUEUE_CAP);

  // bank searched after a possible swap
  assign bank_eff = (active_total_r == '0) ? ~bank_r : bank_r;

  // lowest-numbered non-empty queue of the active bank
  always_comb begin
    sel_found = 1'b0;
    sel_p     = '0;
    for (int i = NUM_PRIO - 1; i >= 0; i--) begin
      if (qsize_r[qidx(bank_eff, PW'(i))] != '0) begin
        sel_found = 1'b1;
        sel_p     = PW'(i);
      end
    end
    sel_q = qidx(bank_eff, sel_p);
  end

  // memory access steering
  always_comb begin
    unique case (state_r)
      S_PUSH_RD: ht_raddr = push_q_r;
      S_SEL:     ht_raddr = sel_q;
      default:   ht_raddr = pop_q_r;
    endcase
    ht_we    = ((state_r == S_PUSH_WR) && push_ok) || (state_r == S_POP_WR);
    ht_waddr = (state_r == S_POP_WR) ? pop_q_r : push_q_r;
    if (state_r == S_POP_WR) begin
      ht_wdata.head = link_rd_r;
      ht_wdata.tail = ht_rd_r.tail;
    end else if (push_size == '0) begin
      ht_wdata.head = push_id_r;
      ht_wdata.tail = push_id_r;
    end else begin
      ht_wdata.head = ht_rd_r.head;
      ht_wdata.tail = push_id_r;
    end
    link_we = (state_r == S_PUSH_WR) && push_ok && (push_size != '0);
  end

  // head/tail memory
  always_ff @(posedge clk) begin
    if (ht_we) begin
      ht_mem[ht_waddr] <= ht_wdata;
    end
    ht_rd_r <= ht_mem[ht_raddr];
  end

  // link memory: written at the old tail, read at the head
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[ht_rd_r.tail] <= push_id_r;
    end
    link_rd_r <= link_mem[ht_rd_r.head];
  end

  // sequencer, scheduler state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      bank_r          <= 1'b0;
      thread_total_r  <= '0;
      active_total_r  <= '0;
      expired_total_r <= '0;
      run_id_r        <= '0;
      run_prio_r      <= '0;
      run_quantum_r   <= '0;
      run_valid_r     <= 1'b0;
      switched_r      <= 1'b0;
      swapped_r       <= 1'b0;
      then_sel_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      for (int i = 0; i < NQ; i++) begin
        qsize_r[i] <= '0;
      end
      for (int i = 0; i < pets_pkg::NUM_QREG; i++) begin
        quantum_r[i] <= pets_pkg::QUANTUM_RST;
      end
    end else begin
      out_valid_r <= 1'b0;

      // quantum table writes
      if (cfg_valid && (cfg_index < pets_pkg::CFG_IDX_W'(pets_pkg::NUM_QREG))) begin
        quantum_r[cfg_index[pets_pkg::QREG_IDX_W-1:0]] <= cfg_data;
      end

      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r  <= in_data;
            state_r <= S_DECIDE;
          end
        end

        // act on the item kind and the running thread
        S_DECIDE: begin
          switched_r <= 1'b0;
          swapped_r  <= 1'b0;
          if (item_r.kind == pets_pkg::KIND_INSERT) begin
            thread_total_r <= inc_sat(thread_total_r);
            active_total_r <= inc_sat(active_total_r);
            if (item_r.is_running) begin
              run_id_r      <= item_r.thread_id;
              run_prio_r    <= item_prio;
              run_quantum_r <= quantum_r[pets_pkg::QREG_IDX_W'(item_prio)];
              run_valid_r   <= 1'b1;
              switched_r    <= 1'b1;
              state_r       <= S_DONE;
            end else begin
              push_q_r   <= qidx(bank_r, item_prio);
              push_id_r  <= item_r.thread_id;
              then_sel_r <= 1'b0;
              state_r    <= S_PUSH_RD;
            end
          end else if (!run_valid_r) begin
            state_r <= S_SEL;
          end else if (item_r.current_exited) begin
            thread_total_r <= dec_sat(thread_total_r);
            active_total_r <= dec_sat(active_total_r);
            state_r        <= S_SEL;
          end else if (thread_total_r != CW'(1)) begin
            if (run_quantum_r <= pets_pkg::QNT_W'(1)) begin
              // quantum used up: move to the expired bank
              push_q_r        <= qidx(~bank_r, run_prio_r);
              push_id_r       <= run_id_r;
              run_quantum_r   <= quantum_r[pets_pkg::QREG_IDX_W'(run_prio_r)];
              active_total_r  <= dec_sat(active_total_r);
              expired_total_r <= inc_sat(expired_total_r);
              then_sel_r      <= 1'b1;
              state_r         <= S_PUSH_RD;
            end else begin
              run_quantum_r <= run_quantum_r - pets_pkg::QNT_W'(1);
              state_r       <= S_DONE;
            end
          end else begin
            state_r <= S_DONE;
          end
        end

        S_PUSH_RD: begin
          state_r <= S_PUSH_WR;
        end

        // append to the queue, full queues drop the item
        S_PUSH_WR: begin
          if (push_ok) begin
            qsize_r[push_q_r] <= push_size + CW'(1);
          end
          state_r <= then_sel_r ? S_SEL : S_DONE;
        end

        // swap banks if needed and pick the successor queue
        S_SEL: begin
          if (active_total_r == '0) begin
            bank_r          <= ~bank_r;
            active_total_r  <= expired_total_r;
            expired_total_r <= '0;
            swapped_r       <= 1'b1;
          end
          if (sel_found) begin
            run_prio_r    <= sel_p;
            run_quantum_r <= quantum_r[pets_pkg::QREG_IDX_W'(sel_p)];
            run_valid_r   <= 1'b1;
            switched_r    <= 1'b1;
            pop_q_r       <= sel_q;
            state_r       <= S_POP_RD;
          end else begin
            run_valid_r <= 1'b0;
            state_r     <= S_DONE;
          end
        end

        // head leaves the queue, its link is fetched
        S_POP_RD: begin
          run_id_r         <= ht_rd_r.head;
          qsize_r[pop_q_r] <= qsize_r[pop_q_r] - CW'(1);
          state_r          <= S_POP_WR;
        end

        S_POP_WR: begin
          state_r <= S_DONE;
        end

        S_DONE: begin
          out_valid_r                  <= 1'b1;
          out_data_r.running_thread    <= run_valid_r ? run_id_r : '0;
          out_data_r.running_ok        <= run_valid_r;
          out_data_r.switched          <= switched_r;
          out_data_r.epoch_swapped     <= swapped_r;
          state_r                      <= S_IDLE;
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
